// ===== hw/rtl/grid_line_blocked_counter_defines.svh =====
// Assertion macros shared by the grid line blocked counter RTL.
`ifndef GRID_LINE_BLOCKED_COUNTER_DEFINES_SVH
`define GRID_LINE_BLOCKED_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// A property checked at every clock edge outside reset.
`define GLBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define GLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GLBC_ASSERT(lbl, prop, msg)
`define GLBC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/glbc_pkg.sv =====
// Shared constants, types and helper functions of the grid line blocked counter.
`timescale 1ns / 1ps

package glbc_pkg;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int COORD_W   = 6;
  localparam int COUNT_W   = 6;
  localparam int MAP_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Endpoints of one line query.
  typedef struct packed {
    logic [COORD_W-1:0] row1;
    logic [COORD_W-1:0] col1;
    logic [COORD_W-1:0] row2;
    logic [COORD_W-1:0] col2;
  } query_t;

  // Map read request from the walker to the map memory.
  typedef struct packed {
    logic              busy;
    logic              issue;
    logic              in_grid;
    logic [MAP_AW-1:0] addr;
  } probe_t;

  function automatic logic cell_in_grid(input logic [COORD_W-1:0] row,
                                        input logic [COORD_W-1:0] col);
    return (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
  endfunction

  function automatic logic [MAP_AW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
    return MAP_AW'(32'(row) * GRID_COLS + 32'(col));
  endfunction

endpackage

// ===== hw/rtl/grid_line_blocked_counter.sv =====
// Top level of the grid line blocked counter: map memory, count and handshakes.
`timescale 1ns / 1ps

// The block holds a 64 by 64 map of wall bits in one synchronous memory and
// answers line queries on it. An input transfer with operation zero writes
// one map cell and produces no result; cells that were never written hold
// unknown data, so a query must only cross written cells. An input transfer
// with operation one names two endpoints and produces one result transfer:
// the number of wall cells strictly between them on the line, walked one
// cell per cycle along the axis with the larger span (the column axis when
// the spans are equal). The walker uses the single read port of the map
// memory once per walked cell. The finished count sits in an output
// register, so the next item is taken while an earlier result is still
// waiting for its consumer; a query holds off further items during its walk,
// and after it only when its own result finds that register still occupied.
// There is no clearing pass after reset.
module grid_line_blocked_counter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [glbc_pkg::COORD_W-1:0] first_row_i,
  input  logic [glbc_pkg::COORD_W-1:0] first_col_i,
  input  logic                         wall_bit_i,
  input  logic [glbc_pkg::COORD_W-1:0] second_row_i,
  input  logic [glbc_pkg::COORD_W-1:0] second_col_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [glbc_pkg::COUNT_W-1:0] blocked_count_o
);
  import glbc_pkg::*;

  `include "grid_line_blocked_counter_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic               in_acc, start;
  query_t             query;
  probe_t             probe;

  // Map storage: one wall bit per cell, read out in the cycle after its address.
  logic               wall_map_q [MAP_DEPTH];
  logic               rd_bit_q;
  logic               rd_valid_q;

  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  logic [COUNT_W-1:0] blocked_count_q;

  // Items are only taken between queries; writes complete in the accept cycle.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (op_e'(operation_i) == OP_QUERY);

  assign query = '{row1: first_row_i, col1: first_col_i,
                   row2: second_row_i, col2: second_col_i};

  glbc_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .query_i (query),
    .probe_o (probe)
  );

  // Write port serves map writes, read port serves the walker.
  always_ff @(posedge clk_i) begin
    if (in_acc && (op_e'(operation_i) == OP_WRITE) &&
        cell_in_grid(first_row_i, first_col_i)) begin
      wall_map_q[cell_addr(first_row_i, first_col_i)] <= wall_bit_i;
    end
    rd_bit_q <= wall_map_q[probe.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      rd_valid_q      <= 1'b0;
      count_q         <= '0;
      out_valid_q     <= 1'b0;
      blocked_count_q <= '0;
    end else begin
      // Cells that fall outside the grid are never counted as walls.
      rd_valid_q <= probe.issue && probe.in_grid;

      if (start) begin
        count_q <= '0;
      end else if (rd_valid_q && rd_bit_q && (count_q != '1)) begin
        count_q <= count_q + 1'b1;
      end

      // A finished count enters the output register once it is free or
      // being taken in this cycle.
      if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
        blocked_count_q <= count_q;
        out_valid_q     <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          // Done once the walker is idle and the last read has been counted.
          if (!probe.busy && !rd_valid_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blocked_count_o = blocked_count_q;

  `GLBC_ASSERT(a_rd_only_in_walk, rd_valid_q |-> (state_q == ST_WALK), "map read outside a walk")
  `GLBC_ASSERT(a_probe_only_in_walk, probe.issue |-> (state_q == ST_WALK),
               "walker issued while idle")
  `GLBC_ASSERT(a_result_from_done, $rose(out_valid_o) |-> $past(state_q == ST_DONE),
               "result without a finished walk")
  `GLBC_ASSERT_NEXT(a_query_starts_walk, start, (state_q == ST_WALK) && (count_q == '0),
                    "query did not start a clean walk")

endmodule

// ===== hw/rtl/glbc_walker.sv =====
// Line walker: steps along the major axis and produces one map read per cycle.
`timescale 1ns / 1ps

module glbc_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  glbc_pkg::query_t  query_i,
  output glbc_pkg::probe_t  probe_o
);
  import glbc_pkg::*;

  // Setup values derived from the query endpoints.
  logic signed [COORD_W:0] dr_s, dc_s;
  logic [COORD_W-1:0]      adr_s, adc_s;
  logic                    row_walk_s, up_s, neg_s;
  logic [COORD_W-1:0]      d_s, a_s, base_k_s, base_o_s;

  // Walk state.
  logic                    busy_q;
  logic                    row_walk_q, up_q, neg_q;
  logic [COORD_W-1:0]      d_q, a_q, base_o_q;
  logic [COORD_W-1:0]      m_q, k_q, q_q, r_q;
  logic                    issue_q, in_grid_q;
  logic [MAP_AW-1:0]       addr_q;

  // Next step.
  logic [COORD_W-1:0]      m_d, k_d, q_d, r_d, o_d, row_d, col_d;
  logic [COORD_W:0]        r_sum;
  logic                    wrap, issue_d;

  always_comb begin
    dr_s  = $signed({1'b0, query_i.row1}) - $signed({1'b0, query_i.row2});
    dc_s  = $signed({1'b0, query_i.col1}) - $signed({1'b0, query_i.col2});
    adr_s = dr_s[COORD_W] ? COORD_W'(-dr_s) : dr_s[COORD_W-1:0];
    adc_s = dc_s[COORD_W] ? COORD_W'(-dc_s) : dc_s[COORD_W-1:0];
    row_walk_s = adr_s > adc_s;
    if (row_walk_s) begin
      d_s  = adr_s;
      a_s  = adc_s;
      up_s = 1'b1;
      if (!dr_s[COORD_W]) begin
        base_k_s = query_i.row2;
        base_o_s = query_i.col2;
        neg_s    = dc_s[COORD_W];
      end else begin
        base_k_s = query_i.row1;
        base_o_s = query_i.col1;
        neg_s    = (dc_s != '0) && !dc_s[COORD_W];
      end
    end else begin
      // Column walks always start from the second endpoint.
      d_s      = adc_s;
      a_s      = adr_s;
      base_k_s = query_i.col2;
      base_o_s = query_i.row2;
      up_s     = (dc_s != '0) && !dc_s[COORD_W];
      neg_s    = dr_s[COORD_W];
    end
  end

  // The quotient of |d_o| * m / |D| is tracked with one compare and subtract,
  // since |d_o| never exceeds |D|.
  always_comb begin
    m_d     = m_q + 1'b1;
    k_d     = up_q ? k_q + 1'b1 : k_q - 1'b1;
    r_sum   = {1'b0, r_q} + {1'b0, a_q};
    wrap    = r_sum >= {1'b0, d_q};
    r_d     = wrap ? COORD_W'(r_sum - {1'b0, d_q}) : r_sum[COORD_W-1:0];
    q_d     = q_q + COORD_W'(wrap);
    o_d     = neg_q ? base_o_q - q_d : base_o_q + q_d;
    issue_d = busy_q && (m_d < d_q);
    row_d   = row_walk_q ? k_d : o_d;
    col_d   = row_walk_q ? o_d : k_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= 1'b0;
    end else begin
      issue_q <= issue_d;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && !issue_d) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_grid_q <= cell_in_grid(row_d, col_d);
    addr_q    <= cell_addr(row_d, col_d);
    if (start_i) begin
      row_walk_q <= row_walk_s;
      up_q       <= up_s;
      neg_q      <= neg_s;
      d_q        <= d_s;
      a_q        <= a_s;
      base_o_q   <= base_o_s;
      k_q        <= base_k_s;
      m_q        <= '0;
      q_q        <= '0;
      r_q        <= '0;
    end else if (issue_d) begin
      m_q <= m_d;
      k_q <= k_d;
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign probe_o = '{busy: busy_q | issue_q, issue: issue_q, in_grid: in_grid_q, addr: addr_q};

endmodule

// ===== bench/tb_grid_line_blocked_counter.sv =====
// Self-checking testbench for the grid line blocked counter.
`timescale 1ns / 1ps

module tb_grid_line_blocked_counter;
  import glbc_pkg::*;

  localparam int TARGET_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 80;
  localparam int DIR_ROWS     = 22;

  // One row of the directed table. When fixed is set, count is the blocked
  // count that the row must return; otherwise the predictor supplies it.
  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] row1;
    logic [COORD_W-1:0] col1;
    logic               wall;
    logic [COORD_W-1:0] row2;
    logic [COORD_W-1:0] col2;
    logic               fixed;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  // Bookkeeping attached to each offered transfer, consumed on acceptance.
  typedef struct {
    bit                 fixed;
    logic [COUNT_W-1:0] count;
  } note_t;

  // Queries in the table are preceded by writes on every cell of their path
  // that was never written, walls for rows with a typed count, so those rows
  // read off the path length directly.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Equal endpoints, at both corners.
    '{OP_QUERY,  6'd0,  6'd0, 1'b0,  6'd0,  6'd0, 1'b1,  6'd0},
    '{OP_QUERY, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63, 1'b1,  6'd0},
    // Adjacent endpoints leave nothing in between.
    '{OP_QUERY,  6'd0,  6'd0, 1'b1,  6'd0,  6'd1, 1'b1,  6'd0},
    // Full row, then one cell cleared and the row walked backwards.
    '{OP_QUERY,  6'd0,  6'd0, 1'b0,  6'd0, 6'd63, 1'b1, 6'd62},
    '{OP_WRITE,  6'd0,  6'd5, 1'b0, 6'd63, 6'd63, 1'b0,  6'd0},
    '{OP_QUERY,  6'd0, 6'd63, 1'b0,  6'd0,  6'd0, 1'b1, 6'd61},
    // Full columns.
    '{OP_QUERY,  6'd0,  6'd0, 1'b0, 6'd63,  6'd0, 1'b1, 6'd62},
    '{OP_QUERY, 6'd63, 6'd63, 1'b0,  6'd0, 6'd63, 1'b1, 6'd62},
    // Full anti-diagonal: equal spans walk the columns.
    '{OP_QUERY, 6'd63,  6'd0, 1'b0,  6'd0, 6'd63, 1'b1, 6'd62},
    '{OP_WRITE, 6'd31, 6'd32, 1'b0, 6'd42, 6'd21, 1'b0,  6'd0},
    '{OP_QUERY,  6'd0, 6'd63, 1'b1, 6'd63,  6'd0, 1'b1, 6'd61},
    // Walls on the endpoints themselves are never counted.
    '{OP_WRITE,  6'd0,  6'd0, 1'b1, 6'd17, 6'd40, 1'b0,  6'd0},
    '{OP_WRITE, 6'd63, 6'd63, 1'b1,  6'd1,  6'd2, 1'b0,  6'd0},
    '{OP_QUERY,  6'd0,  6'd0, 1'b0,  6'd0, 6'd63, 1'b1, 6'd61},
    '{OP_QUERY,  6'd1,  6'd1, 1'b0,  6'd2,  6'd2, 1'b1,  6'd0},
    // Steep lines walking the rows, downward and upward, so that the
    // truncated division rounds from different base points.
    '{OP_QUERY, 6'd40,  6'd3, 1'b0,  6'd2, 6'd10, 1'b0,  6'd0},
    '{OP_QUERY,  6'd2, 6'd10, 1'b1, 6'd40,  6'd3, 1'b0,  6'd0},
    // Shallow and equal-span lines walking the columns, and one steep row walk.
    '{OP_QUERY,  6'd7, 6'd50, 1'b0, 6'd12, 6'd20, 1'b0,  6'd0},
    '{OP_QUERY, 6'd20, 6'd20, 1'b0, 6'd25, 6'd25, 1'b0,  6'd0},
    '{OP_QUERY, 6'd45, 6'd60, 1'b1, 6'd10, 6'd58, 1'b0,  6'd0},
    '{OP_WRITE, 6'd63,  6'd0, 1'b1, 6'd33, 6'd12, 1'b0,  6'd0},
    '{OP_QUERY, 6'd62,  6'd0, 1'b0, 6'd63, 6'd63, 1'b0,  6'd0}
  };

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic               operation_i     = OP_WRITE;
  logic [COORD_W-1:0] first_row_i     = '0;
  logic [COORD_W-1:0] first_col_i     = '0;
  logic               wall_bit_i      = 1'b0;
  logic [COORD_W-1:0] second_row_i    = '0;
  logic [COORD_W-1:0] second_col_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [COUNT_W-1:0] blocked_count_o;

  // Predictor state: the wall map as accepted by the block, and which cells
  // the stimulus has already written (tracked when the transfer is offered).
  bit                 wall_model [MAP_DEPTH];
  bit                 cell_known [MAP_DEPTH];
  logic [COUNT_W-1:0] count_q [$];
  note_t              note_q [$];

  int src_idle_pct  = 24;
  int sink_stall_pct = 67;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int sent_items    = 0;
  int n_queries     = 0;
  int n_writes      = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int cycles        = 0;

  grid_line_blocked_counter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .first_row_i    (first_row_i),
    .first_col_i    (first_col_i),
    .wall_bit_i     (wall_bit_i),
    .second_row_i   (second_row_i),
    .second_col_i   (second_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blocked_count_o(blocked_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Flat map index of a cell, or -1 when the cell lies off the grid.
  function automatic int cell_index(input int row, input int col);
    if (row < 0 || col < 0 || row >= GRID_ROWS || col >= GRID_COLS) begin
      return -1;
    end
    return row * GRID_COLS + col;
  endfunction

  // Lists the cells strictly between two endpoints, ascending along the major
  // axis, and returns how many there are. The minor coordinate is interpolated
  // with division truncated toward zero from the second endpoint, or from the
  // first on row walks where the first endpoint has the lower row.
  function automatic int trace_line(input int r1, input int c1, input int r2,
                                    input int c2, output int cells [64]);
    int dr, dc, lo, hi, k, o, n;
    dr = r1 - r2;
    dc = c1 - c2;
    n  = 0;
    if (dr == 0) begin
      lo = (c1 < c2) ? c1 : c2;
      hi = (c1 < c2) ? c2 : c1;
      for (k = lo + 1; k < hi; k++) begin
        cells[n] = cell_index(r1, k);
        n++;
      end
    end else if (dc == 0) begin
      lo = (r1 < r2) ? r1 : r2;
      hi = (r1 < r2) ? r2 : r1;
      for (k = lo + 1; k < hi; k++) begin
        cells[n] = cell_index(k, c1);
        n++;
      end
    end else if ((dr < 0 ? -dr : dr) > (dc < 0 ? -dc : dc)) begin
      if (r1 > r2) begin
        for (k = r2 + 1; k < r1; k++) begin
          o = dc * (k - r2) / dr + c2;
          cells[n] = cell_index(k, o);
          n++;
        end
      end else begin
        for (k = r1 + 1; k < r2; k++) begin
          o = dc * (k - r1) / dr + c1;
          cells[n] = cell_index(k, o);
          n++;
        end
      end
    end else begin
      lo = (c1 < c2) ? c1 : c2;
      hi = (c1 < c2) ? c2 : c1;
      for (k = lo + 1; k < hi; k++) begin
        o = dr * (k - c2) / dc + r2;
        cells[n] = cell_index(o, k);
        n++;
      end
    end
    return n;
  endfunction

  // Number of walls on the current map strictly between the endpoints.
  function automatic logic [COUNT_W-1:0] blocked_between(input int r1, input int c1,
                                                         input int r2, input int c2);
    int cells [64];
    int n, i, hits;
    n    = trace_line(r1, c1, r2, c2, cells);
    hits = 0;
    for (i = 0; i < n; i++) begin
      if (cells[i] >= 0 && wall_model[cells[i]]) hits++;
    end
    if (hits > 63) hits = 63;
    return COUNT_W'(hits);
  endfunction

  function automatic int near(input int base, input int span);
    int v;
    v = base + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > GRID_ROWS - 1) v = GRID_ROWS - 1;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t ns] mismatch: %s", $realtime, msg);
  endtask

  // Offers one input transfer and returns at the edge where it is taken.
  task automatic offer(input op_e op, input int r1, input int c1, input logic wb,
                       input int r2, input int c2, input bit fixed, input int count);
    note_t nt;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    nt.fixed = fixed;
    nt.count = COUNT_W'(count);
    note_q.push_back(nt);
    if (op == OP_WRITE && cell_index(r1, c1) >= 0) cell_known[cell_index(r1, c1)] = 1'b1;
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    first_row_i  <= COORD_W'(r1);
    first_col_i  <= COORD_W'(c1);
    wall_bit_i   <= wb;
    second_row_i <= COORD_W'(r2);
    second_col_i <= COORD_W'(c2);
    sent_items++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Writes every not yet written cell on the path first, so the query only
  // reads defined map data, then offers the query itself.
  task automatic line_query(input int r1, input int c1, input int r2, input int c2,
                            input logic wb, input bit fixed, input int count,
                            input bit wall_fill);
    int cells [64];
    int n, i;
    n = trace_line(r1, c1, r2, c2, cells);
    for (i = 0; i < n; i++) begin
      if (cells[i] >= 0 && !cell_known[cells[i]]) begin
        offer(OP_WRITE, cells[i] / GRID_COLS, cells[i] % GRID_COLS,
              wall_fill ? 1'b1 : logic'($urandom_range(99) < 40),
              $urandom_range(63), $urandom_range(63), 1'b0, 0);
      end
    end
    offer(OP_QUERY, r1, c1, wb, r2, c2, fixed, count);
  endtask

  // Stops offering until every pending count has been returned.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (count_q.size() != 0);
    @(posedge clk_i);
  endtask

  // Result side: random stalls, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Checks each result transfer, then folds each accepted input transfer
  // into the predictor. Both sides are sampled at the edge that takes them.
  always @(posedge clk_i) begin : watch
    note_t              nt;
    logic [COUNT_W-1:0] want;
    int                 idx;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (count_q.size() == 0) begin
          report_mismatch($sformatf("count %0d with no query pending", blocked_count_o));
        end else begin
          want = count_q.pop_front();
          results_seen++;
          if (blocked_count_o !== want) begin
            report_mismatch($sformatf("blocked_count %0d, expected %0d (result %0d)",
                                      blocked_count_o, want, results_seen));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        nt = note_q.pop_front();
        if (op_e'(operation_i) == OP_QUERY) begin
          n_queries++;
          count_q.push_back(nt.fixed ? nt.count :
                            blocked_between(int'(first_row_i), int'(first_col_i),
                                            int'(second_row_i), int'(second_col_i)));
        end else begin
          n_writes++;
          idx = cell_index(int'(first_row_i), int'(first_col_i));
          if (idx >= 0) wall_model[idx] = wall_bit_i;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out with %0d counts still pending.", count_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    int       i, phase, sel, kind, r1, c1, r2, c2;
    bit       early_hold;
    phase      = 0;
    early_hold = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.op == OP_WRITE) begin
        offer(OP_WRITE, int'(row.row1), int'(row.col1), row.wall, int'(row.row2),
              int'(row.col2), 1'b0, 0);
      end else begin
        line_query(int'(row.row1), int'(row.col1), int'(row.row2), int'(row.col2),
                   row.wall, row.fixed, int'(row.count), row.fixed);
      end
    end
    drain();

    // Random part: 30 percent of the picks overwrite arbitrary cells, the rest
    // are queries, mostly short lines, whose unwritten cells get random walls.
    while (sent_items < TARGET_ITEMS) begin
      if (phase == 0 && !early_hold && sent_items >= 250) begin
        early_hold = 1'b1;
        hold_req   = 1'b1;
      end
      if (phase == 0 && sent_items >= 500) begin
        phase = 1;
        drain();
        src_idle_pct   = 67;
        sink_stall_pct = 24;
      end else if (phase == 1 && sent_items >= 1000) begin
        phase          = 2;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 30) begin
        offer(OP_WRITE, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)),
              $urandom_range(63), $urandom_range(63), 1'b0, 0);
      end else begin
        r1   = $urandom_range(63);
        c1   = $urandom_range(63);
        kind = $urandom_range(99);
        if (kind < 5) begin
          r2 = r1;
          c2 = c1;
        end else if (kind < 60) begin
          r2 = near(r1, 6);
          c2 = near(c1, 6);
        end else if (kind < 88) begin
          r2 = near(r1, 20);
          c2 = near(c1, 20);
        end else begin
          r2 = $urandom_range(63);
          c2 = $urandom_range(63);
        end
        if ($urandom_range(99) < 15) begin
          if ($urandom_range(1)) r2 = r1;
          else c2 = c1;
        end
        line_query(r1, c1, r2, c2, 1'($urandom_range(1)), 1'b0, 0, 1'b0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d transfers in: %0d map writes and %0d line queries.",
             n_queries + n_writes, n_writes, n_queries);
    $display("Checked %0d counts over three idle mixes and two long output hold-offs.",
             results_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
